### hdl/udp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_pkg
// Shared types, constants and fixed-point helpers for the undistortion pipe.
// ----------------------------------------------------------------------------
package udp_pkg;

    localparam int ITERATIONS_DEF = 8;
    localparam int FRAC_BITS      = 28;
    localparam int NORM_SHIFT     = 12;
    localparam int CELL_STAGES    = 8;

    localparam logic signed [31:0] K1_TINY = 32'sd268;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    localparam logic [19:0] CENTER_X_RST = 20'd81920;
    localparam logic [19:0] CENTER_Y_RST = 20'd61440;
    localparam logic [31:0] INV_F_RST    = 32'd8589935;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_INV_FX   = 3'd2,
        REG_INV_FY   = 3'd3,
        REG_K1       = 3'd4,
        REG_K2       = 3'd5,
        REG_P1       = 3'd6,
        REG_P2       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    // saturate a wide signed value into Q4.28
    function automatic logic signed [31:0] sat(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < 48'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Q4.28 product, round half up, saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] pr;
        logic signed [63:0] sh;
        pr = 64'(a) * 64'(b);
        sh = (pr + 64'sd134217728) >>> FRAC_BITS;
        return sat(sh[47:0]);
    endfunction

    function automatic logic signed [31:0] add2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat(48'(a) + 48'(b));
    endfunction

endpackage
`default_nettype wire

### hdl/udp_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_norm
// One-stage normalization: (pixel - center) * inv_focal, rounded to Q4.28.
// ----------------------------------------------------------------------------
module udp_norm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [19:0]        i_pixel,
    input  wire logic [19:0]        i_center,
    input  wire logic [31:0]        i_inv_f,
    output logic                    o_valid,
    output logic signed [31:0]      o_norm
);
    logic signed [20:0] w_diff;
    logic signed [53:0] w_prod;
    logic signed [53:0] w_shift;
    logic               r_valid;
    logic signed [31:0] r_norm;

    assign w_diff  = $signed({1'b0, i_pixel}) - $signed({1'b0, i_center});
    assign w_prod  = 54'(w_diff) * 54'($signed({1'b0, i_inv_f}));
    assign w_shift = (w_prod + 54'sd2048) >>> udp_pkg::NORM_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= udp_pkg::sat(w_shift[47:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;
endmodule
`default_nettype wire

### hdl/udp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_cell
// One refinement step d' = D(p - d), eight register stages deep.
// ----------------------------------------------------------------------------
module udp_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire udp_pkg::t_coef     i_coef,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_px,
    input  wire logic signed [31:0] i_py,
    input  wire logic signed [31:0] i_dx,
    input  wire logic signed [31:0] i_dy,
    output logic                    o_valid,
    output logic signed [31:0]      o_px,
    output logic signed [31:0]      o_py,
    output logic signed [31:0]      o_dx,
    output logic signed [31:0]      o_dy
);
    localparam int NS = udp_pkg::CELL_STAGES;

    logic [NS-1:0]      r_vld;
    logic signed [31:0] r_px [NS];
    logic signed [31:0] r_py [NS];
    logic signed [31:0] r_ux [2:7];
    logic signed [31:0] r_uy [2:7];
    logic signed [31:0] r_x2, r_y2, r_xy2;
    logic signed [31:0] r_r2, r_a, r_b, r_xy3;
    logic signed [31:0] r_k1r2, r_rr, r_p1xy[4:7], r_p2xy[4:7], r_p2a[4:7], r_p1b[4:7];
    logic signed [31:0] r_k1r2_5, r_k2rr;
    logic signed [31:0] r_rad;
    logic signed [31:0] r_uxr, r_uyr;
    logic signed [31:0] r_dx, r_dy;
    logic signed [31:0] w_r2;

    assign w_r2 = udp_pkg::add2(r_x2, r_y2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px[0] <= i_px;
            r_py[0] <= i_py;
            for (int s = 1; s < NS; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
            end
            // stage 1: u = p - d
            r_ux[2] <= udp_pkg::sat(48'(i_px) - 48'(i_dx));
            r_uy[2] <= udp_pkg::sat(48'(i_py) - 48'(i_dy));
            for (int s = 3; s < 8; s++) begin
                r_ux[s] <= r_ux[s-1];
                r_uy[s] <= r_uy[s-1];
            end
            // stage 2: squares and cross term
            r_x2  <= udp_pkg::qmul(r_ux[2], r_ux[2]);
            r_y2  <= udp_pkg::qmul(r_uy[2], r_uy[2]);
            r_xy2 <= udp_pkg::qmul(r_ux[2], r_uy[2]);
            // stage 3: r2 and tangential sums
            r_r2  <= w_r2;
            r_a   <= udp_pkg::sat(48'(w_r2) + (48'(r_x2) <<< 1));
            r_b   <= udp_pkg::sat(48'(w_r2) + (48'(r_y2) <<< 1));
            r_xy3 <= r_xy2;
            // stage 4: coefficient products
            r_k1r2   <= udp_pkg::qmul(i_coef.k1, r_r2);
            r_rr     <= udp_pkg::qmul(r_r2, r_r2);
            r_p1xy[4] <= udp_pkg::qmul(i_coef.p1, r_xy3);
            r_p2xy[4] <= udp_pkg::qmul(i_coef.p2, r_xy3);
            r_p2a[4]  <= udp_pkg::qmul(i_coef.p2, r_a);
            r_p1b[4]  <= udp_pkg::qmul(i_coef.p1, r_b);
            for (int s = 5; s < 8; s++) begin
                r_p1xy[s] <= r_p1xy[s-1];
                r_p2xy[s] <= r_p2xy[s-1];
                r_p2a[s]  <= r_p2a[s-1];
                r_p1b[s]  <= r_p1b[s-1];
            end
            // stage 5: k2 * r2^2
            r_k2rr   <= udp_pkg::qmul(i_coef.k2, r_rr);
            r_k1r2_5 <= r_k1r2;
            // stage 6: radial factor
            r_rad <= udp_pkg::add2(r_k1r2_5, r_k2rr);
            // stage 7
            r_uxr <= udp_pkg::qmul(r_ux[7], r_rad);
            r_uyr <= udp_pkg::qmul(r_uy[7], r_rad);
            // stage 8: new correction
            r_dx <= udp_pkg::sat(48'(r_uxr) + (48'(r_p1xy[7]) <<< 1) + 48'(r_p2a[7]));
            r_dy <= udp_pkg::sat(48'(r_uyr) + (48'(r_p2xy[7]) <<< 1) + 48'(r_p1b[7]));
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_px    = r_px[NS-1];
    assign o_py    = r_py[NS-1];
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
endmodule
`default_nettype wire

### hdl/undistort_pixel_iterative.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// undistort_pixel_iterative
// Normalizes a pixel and removes radial-tangential distortion by a chain of
// refinement cells, one cell per iteration; the correction is bypassed while |k1| <= K1_TINY.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  pixel     i_valid/o_ready, i_pixel_x/y          in
//  result    o_valid/i_ready, o_norm_x/y           out
//  config    psel/penable/pwrite/paddr/pwdata      in, prdata/pready out
//
//  One point per cycle unless the output stalls. The pipe has one normalize
//  stage, eight stages per refinement cell and one output register.
//  The whole pipe advances together; it freezes only while the output
//  register holds a result that is not taken (i_ready low).
//  Reset clears valid flags and loads register defaults.
// ----------------------------------------------------------------------------
module undistort_pixel_iterative #(
    parameter int ITERATIONS = udp_pkg::ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [19:0]        i_pixel_x,
    input  wire logic [19:0]        i_pixel_y,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_norm_x,
    output logic signed [31:0]      o_norm_y,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [19:0]        r_cx, r_cy;
    logic [31:0]        r_ifx, r_ify;
    udp_pkg::t_coef     r_coef;
    udp_pkg::t_reg_idx  w_idx;
    logic               w_wr;
    logic               w_en;

    assign w_idx  = udp_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= udp_pkg::CENTER_X_RST;
            r_cy   <= udp_pkg::CENTER_Y_RST;
            r_ifx  <= udp_pkg::INV_F_RST;
            r_ify  <= udp_pkg::INV_F_RST;
            r_coef <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                udp_pkg::REG_CENTER_X: r_cx      <= pwdata[19:0];
                udp_pkg::REG_CENTER_Y: r_cy      <= pwdata[19:0];
                udp_pkg::REG_INV_FX:   r_ifx     <= pwdata;
                udp_pkg::REG_INV_FY:   r_ify     <= pwdata;
                udp_pkg::REG_K1:       r_coef.k1 <= pwdata;
                udp_pkg::REG_K2:       r_coef.k2 <= pwdata;
                udp_pkg::REG_P1:       r_coef.p1 <= pwdata;
                udp_pkg::REG_P2:       r_coef.p2 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            udp_pkg::REG_CENTER_X: prdata = {12'd0, r_cx};
            udp_pkg::REG_CENTER_Y: prdata = {12'd0, r_cy};
            udp_pkg::REG_INV_FX:   prdata = r_ifx;
            udp_pkg::REG_INV_FY:   prdata = r_ify;
            udp_pkg::REG_K1:       prdata = r_coef.k1;
            udp_pkg::REG_K2:       prdata = r_coef.k2;
            udp_pkg::REG_P1:       prdata = r_coef.p1;
            udp_pkg::REG_P2:       prdata = r_coef.p2;
            default:               prdata = '0;
        endcase
    end

    // pipeline moves unless the output register is full and stalled
    logic r_out_valid;
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    logic               w_nv_x, w_nv_y;
    logic signed [31:0] w_px, w_py;

    udp_norm u_norm_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_pixel(i_pixel_x), .i_center(r_cx), .i_inv_f(r_ifx),
        .o_valid(w_nv_x), .o_norm(w_px)
    );
    udp_norm u_norm_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_pixel(i_pixel_y), .i_center(r_cy), .i_inv_f(r_ify),
        .o_valid(w_nv_y), .o_norm(w_py)
    );

    logic               c_v  [ITERATIONS+1];
    logic signed [31:0] c_px [ITERATIONS+1];
    logic signed [31:0] c_py [ITERATIONS+1];
    logic signed [31:0] c_dx [ITERATIONS+1];
    logic signed [31:0] c_dy [ITERATIONS+1];

    assign c_v[0]  = w_nv_x & w_nv_y;
    assign c_px[0] = w_px;
    assign c_py[0] = w_py;
    assign c_dx[0] = '0;
    assign c_dy[0] = '0;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        udp_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_coef(r_coef),
            .i_valid(c_v[g]), .i_px(c_px[g]), .i_py(c_py[g]),
            .i_dx(c_dx[g]), .i_dy(c_dy[g]),
            .o_valid(c_v[g+1]), .o_px(c_px[g+1]), .o_py(c_py[g+1]),
            .o_dx(c_dx[g+1]), .o_dy(c_dy[g+1])
        );
    end

    logic               w_iter;
    logic signed [31:0] r_ox, r_oy;
    assign w_iter = (r_coef.k1 > udp_pkg::K1_TINY) || (r_coef.k1 < -udp_pkg::K1_TINY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= c_v[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_iter) begin
                r_ox <= udp_pkg::sat(48'(c_px[ITERATIONS]) - 48'(c_dx[ITERATIONS]));
                r_oy <= udp_pkg::sat(48'(c_py[ITERATIONS]) - 48'(c_dy[ITERATIONS]));
            end else begin
                r_ox <= c_px[ITERATIONS];
                r_oy <= c_py[ITERATIONS];
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_norm_x = r_ox;
    assign o_norm_y = r_oy;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output valid after reset");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid) else $error("stall without held result");
    a_norm_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_nv_x == w_nv_y) else $error("normalizer lanes out of step");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(c_v[0])) else $error("pipe moved during stall");
endmodule
`default_nettype wire
